// ===== hw/rtl/eax_pkg.sv =====
package eax_pkg;

   // Token buffer and recipient cap
   localparam int TOKEN_MAX      = 64;
   localparam int MAX_RECIPIENTS = 512;

   // Token banks: one being filled, one draining, the rest waiting in the queue
   localparam int BANKS       = 4;
   localparam int BANK_W      = $clog2(BANKS);
   localparam int TOK_IDX_W   = $clog2(TOKEN_MAX);
   localparam int TOK_LEN_W   = $clog2(TOKEN_MAX + 1);
   localparam int RAM_DEPTH   = BANKS * (2 ** TOK_IDX_W);
   localparam int RAM_AW      = $clog2(RAM_DEPTH);
   localparam int QUEUE_DEPTH = BANKS - 2;
   localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int ROOM_W      = QCNT_W + 1;

   localparam int RCNT_W = $clog2(MAX_RECIPIENTS + 1);
   localparam int SLOT_W = 9;

   // Character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_AT     = 8'h40;

   // One address waiting in a token bank
   typedef struct packed {
      logic [BANK_W-1:0]    bank;
      logic [TOK_LEN_W-1:0] len;
      logic                 sender;
      logic [SLOT_W-1:0]    slot;
      logic                 trunc;
   } desc_type;

   // One result beat
   typedef struct packed {
      logic [7:0]        data;
      logic              last;
      logic              sender;
      logic [SLOT_W-1:0] slot;
      logic              trunc;
   } beat_type;

   // Token store write
   typedef struct packed {
      logic              we;
      logic [RAM_AW-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   // Characters that end a token
   function automatic logic is_bound(input logic [7:0] c);
      return c == CH_NUL || c == CH_SPACE || c == CH_TAB || c == CH_LT || c == CH_GT ||
             c == CH_LPAREN || c == CH_RPAREN || c == CH_CR || c == CH_LF;
   endfunction

endpackage

// ===== hw/rtl/email_address_extractor_unit.sv =====
// Pulls the first '@' token out of each comma-separated segment of a mail header
// value and sends it out one byte per beat, tagged as sender or with its recipient
// slot. The front end takes one character per cycle and writes token bytes into one
// of four banks of a token RAM; a finished address goes as a descriptor into a
// two-entry queue, and the back end reads it out at one byte per cycle while the
// output is taken. The front end stalls only while three addresses are already
// waiting or draining (all other banks taken); the read port of the token RAM sets
// the output rate. No clearing pass runs after reset.
module email_address_extractor_unit import eax_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // line_end
   input  logic [1:0]  req_tuser,   // [0] is_from, [1] new_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] addr_byte, [16:8] recipient_slot
   output logic        rsp_tlast,   // addr_last
   output logic [1:0]  rsp_tuser    // [0] to_sender, [1] truncated
);

   ram_wr_type          wr;
   logic                push, pop, q_valid, busy, room;
   desc_type            push_desc, q_desc;
   logic [QCNT_W-1:0]   q_cnt;
   logic                ram_re;
   logic [RAM_AW-1:0]   ram_raddr;
   logic [7:0]          ram_rdata;

   // Accept only while a free bank remains for the next token
   assign room = (ROOM_W'(q_cnt) + ROOM_W'(busy)) < ROOM_W'(BANKS - 1);

   eax_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .room       (room),
      .wr         (wr),
      .push       (push),
      .desc       (push_desc)
   );

   eax_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (wr.we),
      .waddr (wr.addr),
      .wdata (wr.data),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   eax_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_desc    (q_desc),
      .q_cnt     (q_cnt)
   );

   eax_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_desc     (q_desc),
      .q_pop      (pop),
      .busy       (busy),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hw/rtl/eax_ram.sv =====
module eax_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

// ===== hw/rtl/eax_front.sv =====
module eax_front import eax_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic       req_tlast,   // line_end
   input  logic [1:0] req_tuser,   // [0] is_from, [1] new_message
   input  logic       room,
   output ram_wr_type wr,
   output logic       push,
   output desc_type   desc
);

   logic                 accept;
   logic [7:0]           ch;
   logic                 le, fr, nm;

   logic [TOK_LEN_W-1:0] len_ff, len_in, len_e;
   logic signed [7:0]    nest_ff, nest_in, nest_e;
   logic                 quote_ff, quote_in, quote_e;
   logic                 segdone_ff, segdone_in, segdone_e;
   logic                 has_at_ff, has_at_in, has_at_e;
   logic                 ovf_ff, ovf_in, ovf_e;
   logic [RCNT_W-1:0]    rcnt_ff, rcnt_in, rcnt_e;
   logic [BANK_W-1:0]    bank_ff, bank_in;

   logic                 capped, split, delim, emit;
   logic [TOK_LEN_W-1:0] len_n;
   logic                 has_at_n, ovf_n;

   assign req_tready = room;
   assign accept     = req_tvalid & room;
   assign ch         = req_tdata;
   assign le         = req_tlast;
   assign fr         = req_tuser[0];
   assign nm         = req_tuser[1];

   // New message clears line state and the recipient count before the byte
   always_comb begin
      len_e     = nm ? '0 : len_ff;
      nest_e    = nm ? '0 : nest_ff;
      quote_e   = nm ? 1'b0 : quote_ff;
      segdone_e = nm ? 1'b0 : segdone_ff;
      has_at_e  = nm ? 1'b0 : has_at_ff;
      ovf_e     = nm ? 1'b0 : ovf_ff;
      rcnt_e    = nm ? '0 : rcnt_ff;
   end

   assign capped = rcnt_e >= RCNT_W'(MAX_RECIPIENTS);
   assign split  = (ch == CH_COMMA) && (nest_e == 8'sd0) && !quote_e;
   assign delim  = split || is_bound(ch);

   // Token after this byte joins it
   always_comb begin
      len_n    = len_e;
      ovf_n    = ovf_e;
      has_at_n = has_at_e;
      if (!delim) begin
         if (len_e < TOK_LEN_W'(TOKEN_MAX)) begin
            len_n = len_e + TOK_LEN_W'(1);
         end else begin
            ovf_n = 1'b1;
         end
         if (ch == CH_AT) begin
            has_at_n = 1'b1;
         end
      end
   end

   assign emit = (delim || le) && has_at_n && !segdone_e && (len_n != '0);

   // Classify the byte and update the line state
   always_comb begin
      len_in     = len_ff;
      nest_in    = nest_ff;
      quote_in   = quote_ff;
      segdone_in = segdone_ff;
      has_at_in  = has_at_ff;
      ovf_in     = ovf_ff;
      rcnt_in    = rcnt_ff;
      bank_in    = bank_ff;
      wr         = '0;
      push       = 1'b0;
      desc       = '0;
      if (accept) begin
         len_in     = len_e;
         nest_in    = nest_e;
         quote_in   = quote_e;
         segdone_in = segdone_e;
         has_at_in  = has_at_e;
         ovf_in     = ovf_e;
         rcnt_in    = rcnt_e;
         if (!capped) begin
            // Quote and nesting
            if (!split) begin
               if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
                  quote_in = !quote_e;
               end else if (ch == CH_LPAREN || ch == CH_LT) begin
                  if (nest_e != 8'sd127) nest_in = nest_e + 8'sd1;
               end else if (ch == CH_RPAREN || ch == CH_GT) begin
                  if (nest_e != -8'sd128) nest_in = nest_e - 8'sd1;
               end
            end
            // Store the byte in the current bank
            if (!delim && (len_e < TOK_LEN_W'(TOKEN_MAX))) begin
               wr.we   = 1'b1;
               wr.addr = {bank_ff, len_e[TOK_IDX_W-1:0]};
               wr.data = ch;
            end
            len_in    = len_n;
            ovf_in    = ovf_n;
            has_at_in = has_at_n;
            // Hand a finished address to the back end
            if (emit) begin
               push        = 1'b1;
               desc.bank   = bank_ff;
               desc.len    = len_n;
               desc.sender = fr;
               desc.slot   = fr ? '0 : SLOT_W'(rcnt_e);
               desc.trunc  = ovf_n;
               segdone_in  = 1'b1;
               bank_in     = bank_ff + BANK_W'(1);
               if (!fr) rcnt_in = rcnt_e + RCNT_W'(1);
            end
            if (delim || le) begin
               len_in    = '0;
               has_at_in = 1'b0;
               ovf_in    = 1'b0;
            end
            if (split) begin
               segdone_in = 1'b0;
               nest_in    = '0;
               quote_in   = 1'b0;
            end
            if (le) begin
               nest_in    = '0;
               quote_in   = 1'b0;
               segdone_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         nest_ff    <= '0;
         quote_ff   <= 1'b0;
         segdone_ff <= 1'b0;
         has_at_ff  <= 1'b0;
         ovf_ff     <= 1'b0;
         rcnt_ff    <= '0;
         bank_ff    <= '0;
      end else begin
         len_ff     <= len_in;
         nest_ff    <= nest_in;
         quote_ff   <= quote_in;
         segdone_ff <= segdone_in;
         has_at_ff  <= has_at_in;
         ovf_ff     <= ovf_in;
         rcnt_ff    <= rcnt_in;
         bank_ff    <= bank_in;
      end
   end

endmodule

// ===== hw/rtl/eax_queue.sv =====
module eax_queue import eax_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  desc_type          push_desc,
   input  logic              pop,
   output logic              q_valid,
   output desc_type          q_desc,
   output logic [QCNT_W-1:0] q_cnt
);

   desc_type            mem_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]   wptr_ff, wptr_in;
   logic [QIDX_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign q_valid = cnt_ff != '0;
   assign q_desc  = mem_ff[rptr_ff];
   assign q_cnt   = cnt_ff;

   // Advance pointers with wrap
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + QIDX_W'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + QIDX_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_desc;
      end
   end

   // Front end only pushes with a free bank, so the queue never overflows;
   // a push into a full queue is fine when the head leaves in the same cycle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> ((cnt_ff < QCNT_W'(QUEUE_DEPTH)) || pop))
      else $error("descriptor queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != '0))
      else $error("descriptor queue underflow");

endmodule

// ===== hw/rtl/eax_back.sv =====
module eax_back import eax_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  desc_type          q_desc,
   output logic              q_pop,
   output logic              busy,
   output logic              ram_re,
   output logic [RAM_AW-1:0] ram_raddr,
   input  logic [7:0]        ram_rdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // [7:0] addr_byte, [16:8] recipient_slot
   output logic              rsp_tlast,   // addr_last
   output logic [1:0]        rsp_tuser    // [0] to_sender, [1] truncated
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam int OUT_DEPTH = 2;

   state_type            state_ff;
   desc_type             desc_ff;
   logic [TOK_IDX_W-1:0] k_ff;
   logic                 pend_ff;
   beat_type             meta_ff;

   beat_type             fifo_ff [OUT_DEPTH];
   logic                 head_ff;
   logic [1:0]           cnt_ff, cnt_in;
   logic [1:0]           occ;
   logic                 pop, issue, last_read;
   beat_type             head_beat;
   beat_type             cap_beat;

   assign pop       = rsp_tvalid & rsp_tready;
   assign occ       = cnt_ff + 2'(pend_ff);
   assign issue     = (state_ff == ST_RUN) && ((occ < 2'(OUT_DEPTH)) ||
                      ((occ == 2'(OUT_DEPTH)) && pop));
   assign last_read = (TOK_LEN_W'(k_ff) + TOK_LEN_W'(1)) == desc_ff.len;

   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign busy      = state_ff == ST_RUN;
   assign ram_re    = issue;
   assign ram_raddr = {desc_ff.bank, k_ff};

   // Sequence reads through one bank
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= issue;
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  desc_ff  <= q_desc;
                  k_ff     <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (issue) begin
                  meta_ff.data   <= '0;
                  meta_ff.last   <= last_read;
                  meta_ff.sender <= desc_ff.sender;
                  meta_ff.slot   <= desc_ff.slot;
                  meta_ff.trunc  <= desc_ff.trunc;
                  k_ff           <= k_ff + TOK_IDX_W'(1);
                  if (last_read) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Output buffer count
   always_comb begin
      cnt_in = cnt_ff;
      if (pend_ff && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !pend_ff) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (pop) begin
            head_ff <= !head_ff;
         end
      end
   end

   // Merge read data with its tags
   always_comb begin
      cap_beat      = meta_ff;
      cap_beat.data = ram_rdata;
   end

   // Capture read data with its tags
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         fifo_ff[head_ff ^ cnt_ff[0]] <= cap_beat;
      end
   end

   assign head_beat  = fifo_ff[head_ff];
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = {7'd0, head_beat.slot, head_beat.data};
   assign rsp_tlast  = head_beat.last;
   assign rsp_tuser  = {head_beat.trunc, head_beat.sender};

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(OUT_DEPTH))
      else $error("output buffer count out of range");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && (cnt_ff == 2'(OUT_DEPTH)) && !pop))
      else $error("read data arrived with output buffer full");

   a_run_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (desc_ff.len != '0))
      else $error("draining an empty address");

endmodule
